[design/sau_pkg.sv]
// Shared types, constants and helpers of the stack arithmetic unit.
package sau_pkg;

  // Stack geometry and word size
  localparam int STACK_DEPTH = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_WIDTH);

  // Field widths of the command and result beats
  localparam int OP_W          = 3;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_FIELD_W = 9;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MUL  = 3'd4,
    OP_MOD  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_FIX,
    S_WRITE
  } sau_state_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] push_value;
  } sau_cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] top_value;
    logic [DEPTH_FIELD_W-1:0]  depth;
  } sau_result_t;

  // Sign-extend or wrap a pushed value to the stack word
  function automatic word_t push_to_word(logic signed [VALUE_W-1:0] v);
    return word_t'(v);
  endfunction

  // Sign-extend or cut a stack word to the result field
  function automatic logic signed [VALUE_W-1:0] word_to_field(word_t w);
    return VALUE_W'($signed(w));
  endfunction

  // Absolute value as an unsigned word; the most negative value maps to 2^(W-1)
  function automatic word_t magnitude(word_t w);
    return w[DATA_WIDTH-1] ? (word_t'(0) - w) : w;
  endfunction

endpackage

[design/sau_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, register one read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/stack_arithmetic_unit_core.sv]
// Stack arithmetic unit: stack in RAM, cached top, iterative divider.
//
// Integer stack unit: each command beat carries one opcode (push, add, sub,
// div, mul, mod). Every command yields exactly one result beat on result,
// marked by done for a single cycle; the receiver cannot stall it. Push,
// unknown opcodes and every error finish in the idle state: done rises in the
// cycle after the command is taken and busy stays low, so commands may
// follow back to back. Add, sub and mul read the second entry from the stack
// RAM in the read state, compute, and write the result back in the write
// state; done rises in the cycle after the write. Div and mod run a
// restoring divider one quotient bit per cycle, then fix the sign and write
// back, with done likewise. The top entry is held in a register beside the
// RAM, so each operation needs a single RAM read. Errors leave the stack unchanged.
module stack_arithmetic_unit_core
  import sau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  sau_cmd_t    cmd,
  output logic        busy,
  output logic        done,
  output sau_result_t result
);

  sau_state_t state, state_next;

  logic [COUNT_W-1:0]   count;
  word_t                top_reg;
  word_t                res_reg;
  logic [OP_W-1:0]      op_reg;
  status_t              status_reg;
  word_t                rem;
  word_t                quo;
  word_t                dvs;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 neg_res;

  logic                 accept;
  logic                 is_arith;
  logic                 is_divop;
  logic                 enough;
  logic                 full;
  logic                 arith_go;
  logic                 push_ok;
  logic [ADDR_W-1:0]    below_addr;
  word_t                push_word;
  word_t                mem_rdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  word_t                mem_wdata;

  logic [DATA_WIDTH:0]  div_shift;
  logic [DATA_WIDTH:0]  div_trial;
  word_t                rem_next;
  word_t                quo_next;

  // Decode the command beat
  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign is_arith   = (cmd.op == OP_ADD) || (cmd.op == OP_SUB) || (cmd.op == OP_DIV) ||
                      (cmd.op == OP_MUL) || (cmd.op == OP_MOD);
  assign is_divop   = (cmd.op == OP_DIV) || (cmd.op == OP_MOD);
  assign enough     = (count >= COUNT_W'(2));
  assign full       = (count == COUNT_W'(STACK_DEPTH));
  assign arith_go   = accept && is_arith && enough && !(is_divop && (top_reg == '0));
  assign push_ok    = accept && (cmd.op == OP_PUSH) && !full;
  assign push_word  = push_to_word(cmd.push_value);
  assign below_addr = ADDR_W'(count - COUNT_W'(2));

  // Stack RAM; the only read is issued on accept and never meets a write
  sau_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (below_addr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  state_next = arith_go ? S_READ : S_IDLE;
      S_READ:  state_next = ((op_reg == OP_DIV) || (op_reg == OP_MOD)) ? S_DIV : S_WRITE;
      S_DIV:   state_next = (div_cnt == '0) ? S_FIX : S_DIV;
      S_FIX:   state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM write controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(count);
    mem_wdata = push_word;
    case (state)
      S_IDLE: begin
        mem_we = push_ok;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = below_addr;
        mem_wdata = res_reg;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // One restoring division step
  always_comb begin
    div_shift = {rem, quo[DATA_WIDTH-1]};
    div_trial = div_shift - {1'b0, dvs};
    if (!div_trial[DATA_WIDTH]) begin
      rem_next = div_trial[DATA_WIDTH-1:0];
      quo_next = {quo[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_next = div_shift[DATA_WIDTH-1:0];
      quo_next = {quo[DATA_WIDTH-2:0], 1'b0};
    end
  end

  // Advance the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: entry count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= accept && !arith_go;
          if (push_ok) begin
            count <= count + COUNT_W'(1);
          end
        end
        S_WRITE: begin
          done  <= 1'b1;
          count <= count - COUNT_W'(1);
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  // Datapath: cached top, result, divider and status
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_reg <= cmd.op;
          if (cmd.op == OP_PUSH) begin
            if (full) begin
              status_reg <= ST_FULL;
            end else begin
              status_reg <= ST_OK;
              top_reg    <= push_word;
            end
          end else if (is_arith) begin
            if (!enough) begin
              status_reg <= ST_SHORT;
            end else if (is_divop && (top_reg == '0)) begin
              status_reg <= ST_DIV_ZERO;
            end else begin
              status_reg <= ST_OK;
            end
          end else begin
            status_reg <= ST_OK;
          end
        end
      end
      S_READ: begin
        case (op_reg)
          OP_ADD:  res_reg <= mem_rdata + top_reg;
          OP_SUB:  res_reg <= mem_rdata - top_reg;
          OP_MUL:  res_reg <= DATA_WIDTH'(mem_rdata * top_reg);
          default: res_reg <= '0;
        endcase
        rem     <= '0;
        quo     <= magnitude(mem_rdata);
        dvs     <= magnitude(top_reg);
        div_cnt <= DIV_CNT_W'(DATA_WIDTH - 1);
        neg_res <= (op_reg == OP_DIV) ? (mem_rdata[DATA_WIDTH-1] ^ top_reg[DATA_WIDTH-1])
                                      : mem_rdata[DATA_WIDTH-1];
      end
      S_DIV: begin
        rem     <= rem_next;
        quo     <= quo_next;
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      S_FIX: begin
        if (op_reg == OP_DIV) begin
          res_reg <= neg_res ? (word_t'(0) - quo) : quo;
        end else begin
          res_reg <= neg_res ? (word_t'(0) - rem) : rem;
        end
      end
      S_WRITE: begin
        top_reg <= res_reg;
      end
      default: begin
        res_reg <= res_reg;
      end
    endcase
  end

  // Result beat from the post-step state
  assign result.status    = status_reg;
  assign result.top_value = (count == '0) ? '0 : word_to_field(top_reg);
  assign result.depth     = DEPTH_FIELD_W'(count);

  // Writeback always delivers a beat
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> done)
    else $error("writeback without result beat");

  // Commands that need no RAM read answer in the next cycle
  a_quick_done: assert property (@(posedge clk) disable iff (rst)
    (accept && !arith_go) |=> (done && (state == S_IDLE)))
    else $error("one-cycle command without result beat");

  // Errors leave the entry count untouched
  a_error_stable: assert property (@(posedge clk) disable iff (rst)
    (accept && !arith_go && ((cmd.op == OP_DIV) || (cmd.op == OP_MOD) || (cmd.op == OP_ADD) ||
     (cmd.op == OP_SUB) || (cmd.op == OP_MUL) || full)) |=> $stable(count))
    else $error("error changed the stack");

  // Count stays within the stack
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  // No result beat while an operation is still in flight
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    ((state == S_READ) || (state == S_DIV) || (state == S_FIX)) |-> !done)
    else $error("result beat during operation");

endmodule

[verif/sau_checker.sv]
// Checker for the stack arithmetic unit: stack predictor and result scoreboard.
`timescale 1ns / 100ps

module sau_checker
  import sau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  sau_cmd_t    cmd,
  input  logic        done,
  input  sau_result_t result,
  output int          errors,
  output int          pending
);

  // Predicted stack contents and depth
  word_t       stack_words [STACK_DEPTH];
  int          stack_count;
  sau_result_t expected_results [$];
  sau_result_t oldest;
  int          fail_count;
  int          pending_count;

  assign errors  = fail_count;
  assign pending = pending_count;

  initial fail_count = 0;

  task automatic report_error(input string msg);
    $display("sau_checker: %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Apply one command beat to the predicted stack and return its result beat
  function automatic sau_result_t apply_command(input sau_cmd_t c);
    sau_result_t r;
    word_t       top_word;
    word_t       second_word;
    word_t       combined;
    longint      dividend;
    longint      divisor;
    r.status = ST_OK;
    case (c.op)
      OP_PUSH: begin
        if (stack_count >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_words[stack_count] = word_t'(c.push_value);
          stack_count++;
        end
      end
      OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD: begin
        if (stack_count < 2) begin
          r.status = ST_SHORT;
        end else begin
          top_word    = stack_words[stack_count - 1];
          second_word = stack_words[stack_count - 2];
          if ((c.op == OP_DIV || c.op == OP_MOD) && top_word == '0) begin
            r.status = ST_DIV_ZERO;
          end else begin
            // Divide in 64 bits so the most negative over minus one wraps cleanly
            dividend = longint'($signed(second_word));
            divisor  = longint'($signed(top_word));
            case (c.op)
              OP_ADD:  combined = second_word + top_word;
              OP_SUB:  combined = second_word - top_word;
              OP_MUL:  combined = second_word * top_word;
              OP_DIV:  combined = word_t'(dividend / divisor);
              default: combined = word_t'(dividend % divisor);
            endcase
            stack_words[stack_count - 2] = combined;
            stack_count--;
          end
        end
      end
      default: begin
        // Unknown opcode: leave the stack alone
      end
    endcase
    r.top_value = (stack_count > 0) ? $signed(stack_words[stack_count - 1]) : '0;
    r.depth     = DEPTH_FIELD_W'(stack_count);
    return r;
  endfunction

  // Check result beats first, then queue the prediction for a new command beat
  always @(posedge clk) begin
    if (rst) begin
      stack_count = 0;
      expected_results.delete();
      pending_count <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_error("result beat with no command outstanding");
        end else begin
          oldest = expected_results.pop_front();
          if (result.status !== oldest.status)
            report_error($sformatf("status got %0d expected %0d",
                                   result.status, oldest.status));
          if (result.top_value !== oldest.top_value)
            report_error($sformatf("top_value got %0d expected %0d",
                                   result.top_value, oldest.top_value));
          if (result.depth !== oldest.depth)
            report_error($sformatf("depth got %0d expected %0d",
                                   result.depth, oldest.depth));
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_command(cmd));
      pending_count <= expected_results.size();
    end
  end

endmodule

[verif/tb_stack_arithmetic_unit_core.sv]
// Testbench top for the stack arithmetic unit: clock, reset, command stimulus, verdict.
`timescale 1ns / 100ps

module tb_stack_arithmetic_unit_core;
  import sau_pkg::*;

  // Opcodes outside the defined set
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};

  localparam int RANDOM_ITEMS   = 1800;
  localparam int FILL_PUSHES    = STACK_DEPTH + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  sau_cmd_t    cmd;
  sau_result_t result;
  int          errors;
  int          pending;
  int          idle_cycles;
  bit          burst_mode;
  int          random_count;
  int          episode_len;
  int          push_pct;
  logic [OP_W-1:0] next_op;

  stack_arithmetic_unit_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  sau_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_stack_arithmetic_unit_core: done, errors");
      $finish;
    end
  end

  // Mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Bias values toward the extremes and small magnitudes
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5, 6:    return $signed($urandom_range(0, 40)) - 20;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int push_share);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_share) return OP_PUSH;
    if (roll >= 97) return $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
    return OP_W'($urandom_range(int'(OP_ADD), int'(OP_MOD)));
  endfunction

  // Present one command beat, hold it until taken, then, outside burst mode, idle for a random gap
  task automatic issue(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
    sau_cmd_t c;
    int       gap;
    c.op         = op;
    c.push_value = value;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new commands until every outstanding result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= '0;
    idle_cycles <= 0;
    burst_mode  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: short stack, zero divisor, wrap cases, unknown opcodes
    issue(OP_ADD, pick_value());
    issue(OP_PUSH, VALUE_MIN);
    issue(OP_DIV, pick_value());
    issue(OP_PUSH, -1);
    issue(OP_DIV, pick_value());
    issue(OP_PUSH, -1);
    issue(OP_MOD, pick_value());
    issue(OP_PUSH, 0);
    issue(OP_DIV, pick_value());
    issue(OP_MOD, pick_value());
    issue(OP_UNUSED_6, pick_value());
    issue(OP_UNUSED_7, pick_value());
    issue(OP_ADD, pick_value());
    issue(OP_PUSH, VALUE_MAX);
    issue(OP_ADD, pick_value());
    issue(OP_PUSH, 1);
    issue(OP_ADD, pick_value());
    issue(OP_PUSH, VALUE_MAX);
    issue(OP_SUB, pick_value());
    issue(OP_PUSH, -7);
    issue(OP_PUSH, 2);
    issue(OP_DIV, pick_value());
    issue(OP_PUSH, 2);
    issue(OP_MOD, pick_value());
    issue(OP_MUL, pick_value());
    wait_drained();

    // Fill past the top so pushes hit a full stack, with no gaps
    burst_mode   = 1'b1;
    random_count = 0;
    repeat (FILL_PUSHES) begin
      issue(OP_PUSH, pick_value());
      random_count++;
    end

    // Random episodes that drain, churn or refill the stack
    while (random_count < RANDOM_ITEMS) begin
      burst_mode  = ($urandom_range(3) == 0);
      episode_len = $urandom_range(10, 80);
      case ($urandom_range(9))
        0, 1, 2: push_pct = 10;
        3, 4:    push_pct = 75;
        default: push_pct = 45;
      endcase
      if ($urandom_range(29) == 0) begin
        episode_len = FILL_PUSHES;
        push_pct    = 100;
      end
      repeat (episode_len) begin
        next_op = pick_op(push_pct);
        issue(next_op, pick_value());
        if (next_op <= OP_MOD) random_count++;
      end
      if ($urandom_range(6) == 0) wait_drained();
    end

    // Let the last results come back, then give the verdict
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_stack_arithmetic_unit_core: done, clean");
    end else begin
      $display("tb_stack_arithmetic_unit_core: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/sau_pkg.sv
design/sau_ram.sv
design/stack_arithmetic_unit_core.sv
verif/sau_checker.sv
verif/tb_stack_arithmetic_unit_core.sv
